[design/dpsm_pkg.sv]
// Shared types and constants for the delimiter pair sequence matcher.
package dpsm_pkg;

    localparam int RULES_HW = 4;
    localparam int RULE_IDX_W = 2;
    localparam int PATTERN_W = 64;
    localparam int PAIR_CNT_W = 3;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic       found;
        logic [2:0] slot;
        logic [5:0] start;
        logic [6:0] length;
    } t_match;

    typedef struct packed {
        logic [2:0]                            rules_on;
        logic [RULES_HW-1:0][PATTERN_W-1:0]    pattern;
        logic [RULES_HW*PAIR_CNT_W-1:0]        pair_counts;
    } t_cfg;

    typedef struct packed {
        logic       scan_start;
        logic       advance;
        logic       last;
        logic       slot_ok;
        logic [2:0] slot;
        logic [7:0] char_value;
    } t_rule_ctrl;

endpackage

[design/delimiter_pair_sequence_matcher.sv]
// Top level of the delimiter pair sequence matcher.
// Slot strings enter on the s_axis channel, one byte per beat: tdata carries
// the byte, tuser carries the scan start flag and the slot number, and tlast
// marks the final byte of a slot string. A zero byte ends the string early.
// Each beat is absorbed in the cycle it is accepted; a beat that ends a string
// takes a snapshot of the stored match of every active rule.
// The m_axis channel then sends one beat per active rule, rule 0 first, with
// tlast on the final rule. The snapshot is held in the snapshot register and
// then loaded into the serializer, which sends one beat per cycle while the
// receiver is ready. Bytes are taken every cycle while no snapshot waits. One
// snapshot can wait while another is being sent; while it waits and the
// serializer is still busy, s_axis_tready drops until the serializer picks it
// up, so a long receiver stall holds back the input.
// Registers are written through the APB port at byte address 8 times their
// index and should only change while the block is idle.
// Reset clears the registers, all rule state and any pending report.
module delimiter_pair_sequence_matcher #(
    parameter int SLOT_COUNT     = 8,
    parameter int SLOT_BYTES     = 64,
    parameter int RULE_COUNT_MAX = 4,
    parameter int PAIRS_MAX      = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_value
    input  logic [3:0]  s_axis_tuser,   // scan_start, slot_index[2:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // rule_id[1:0], found, match_slot[2:0],
                                        // match_start[5:0], match_length[6:0], zero pad
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int POS_W = $clog2(SLOT_BYTES + 1);

    dpsm_pkg::t_cfg       w_cfg;
    logic [POS_W-1:0]     r_pos, n_pos, w_pos_eff;
    logic                 r_ended, n_ended, w_ended_eff;
    logic                 w_accept, w_step_ok, w_report, w_push;
    logic [2:0]           w_nr;
    logic [7:0]           w_char;
    logic                 w_sc;
    logic [2:0]           w_slot;
    logic                 w_full;
    dpsm_pkg::t_match     w_match [dpsm_pkg::RULES_HW];

    dpsm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_char      = s_axis_tdata;
    assign w_sc        = s_axis_tuser[0];
    assign w_slot      = s_axis_tuser[3:1];
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_nr        = (w_cfg.rules_on > 3'(RULE_COUNT_MAX)) ? 3'(RULE_COUNT_MAX)
                                                               : w_cfg.rules_on;
    assign w_ended_eff = w_sc ? 1'b0 : r_ended;
    assign w_pos_eff   = w_sc ? '0 : r_pos;
    assign w_step_ok   = !w_ended_eff && (w_char != 8'd0) && (w_pos_eff < POS_W'(SLOT_BYTES));
    assign w_report    = w_accept && !w_ended_eff && ((w_char == 8'd0) || s_axis_tlast);
    assign w_push      = w_report && (w_nr != 3'd0);

    always_comb begin
        n_pos   = r_pos;
        n_ended = r_ended;
        if (w_accept) begin
            n_pos   = w_step_ok ? w_pos_eff + POS_W'(1) : w_pos_eff;
            n_ended = w_ended_eff || (w_char == 8'd0);
            if (s_axis_tlast) begin
                n_pos   = '0;
                n_ended = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ended <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_ended <= n_ended;
        end
    end

    for (genvar g = 0; g < dpsm_pkg::RULES_HW; g++) begin : g_rule
        dpsm_pkg::t_rule_ctrl w_ctrl;

        assign w_ctrl.scan_start = w_accept && w_sc;
        assign w_ctrl.advance    = w_accept && w_step_ok && (3'(g) < w_nr);
        assign w_ctrl.last       = w_accept && s_axis_tlast;
        assign w_ctrl.slot_ok    = 7'(w_slot) < 7'(SLOT_COUNT);
        assign w_ctrl.slot       = w_slot;
        assign w_ctrl.char_value = w_char;

        dpsm_rule_unit #(
            .PAIRS_MAX (PAIRS_MAX),
            .POS_W     (POS_W)
        ) u_rule (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_pos        (w_pos_eff),
            .i_pattern    (w_cfg.pattern[g]),
            .i_pair_count (w_cfg.pair_counts[g*dpsm_pkg::PAIR_CNT_W +: dpsm_pkg::PAIR_CNT_W]),
            .o_match      (w_match[g])
        );
    end

    dpsm_report_queue u_report (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_nr       (w_nr),
        .i_match    (w_match),
        .o_full     (w_full),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

    assign s_axis_tready = !w_full;

`ifndef SYNTHESIS
    a_report_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> ##2 m_axis_tvalid)
        else $error("no report beat presented after a string end");

    a_last_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[1:0] == 2'(w_nr - 3'd1)))
        else $error("final report beat is not the last active rule");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(SLOT_BYTES))
        else $error("byte position ran past the slot size");
`endif

endmodule

[design/dpsm_cfg_regs.sv]
// Register file behind the configuration port.
module dpsm_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output dpsm_pkg::t_cfg     o_cfg
);

    typedef enum logic [2:0] {
        REG_RULE_COUNT  = 3'd0,
        REG_PATTERN_0   = 3'd1,
        REG_PATTERN_1   = 3'd2,
        REG_PATTERN_2   = 3'd3,
        REG_PATTERN_3   = 3'd4,
        REG_PAIR_COUNTS = 3'd5
    } t_reg_idx;

    dpsm_pkg::t_cfg r_cfg;
    t_reg_idx       w_idx;
    logic           w_write;

    assign pready  = 1'b1;
    assign w_idx   = t_reg_idx'(paddr[5:3]);
    assign w_write = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_write) begin
            case (w_idx)
                REG_RULE_COUNT:  r_cfg.rules_on    <= pwdata[2:0];
                REG_PATTERN_0:   r_cfg.pattern[0]  <= pwdata;
                REG_PATTERN_1:   r_cfg.pattern[1]  <= pwdata;
                REG_PATTERN_2:   r_cfg.pattern[2]  <= pwdata;
                REG_PATTERN_3:   r_cfg.pattern[3]  <= pwdata;
                REG_PAIR_COUNTS: r_cfg.pair_counts <= pwdata[11:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_RULE_COUNT:  prdata = {61'd0, r_cfg.rules_on};
            REG_PATTERN_0:   prdata = r_cfg.pattern[0];
            REG_PATTERN_1:   prdata = r_cfg.pattern[1];
            REG_PATTERN_2:   prdata = r_cfg.pattern[2];
            REG_PATTERN_3:   prdata = r_cfg.pattern[3];
            REG_PAIR_COUNTS: prdata = {52'd0, r_cfg.pair_counts};
            default:         prdata = '0;
        endcase
    end

endmodule

[design/dpsm_rule_unit.sv]
// Per-rule pair search state and stored first match.
module dpsm_rule_unit #(
    parameter int PAIRS_MAX = 4,
    parameter int POS_W     = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dpsm_pkg::t_rule_ctrl      i_ctrl,
    input  logic [POS_W-1:0]          i_pos,
    input  logic [63:0]               i_pattern,
    input  logic [2:0]                i_pair_count,
    output dpsm_pkg::t_match          o_match
);

    logic [2:0]       r_prog, e_prog, n_prog;
    logic             r_seek, e_seek, n_seek;
    logic [POS_W-1:0] r_cs, e_cs, n_cs;
    dpsm_pkg::t_match r_st, e_st, n_st;
    logic             w_enabled;
    logic [15:0]      w_pair;
    logic [8:0]       w_len;

    always_comb begin
        e_prog = i_ctrl.scan_start ? 3'd0 : r_prog;
        e_seek = i_ctrl.scan_start ? 1'b0 : r_seek;
        e_cs   = i_ctrl.scan_start ? '0 : r_cs;
        e_st   = i_ctrl.scan_start ? '0 : r_st;

        w_enabled = (i_pair_count != 3'd0) && (i_pair_count <= 3'(PAIRS_MAX))
                    && (e_prog < i_pair_count);
        w_pair = i_pattern[{e_prog[1:0], 4'd0} +: 16];
        w_len  = 9'(i_pos) - 9'(e_cs) + 9'd1;

        n_prog = e_prog;
        n_seek = e_seek;
        n_cs   = e_cs;
        n_st   = e_st;

        if (i_ctrl.advance && w_enabled) begin
            if (e_seek) begin
                if (i_ctrl.char_value == w_pair[15:8]) begin
                    n_seek = 1'b0;
                    n_prog = e_prog + 3'd1;
                    if ((e_prog + 3'd1 == i_pair_count) && !e_st.found && i_ctrl.slot_ok) begin
                        n_st.found  = 1'b1;
                        n_st.slot   = i_ctrl.slot;
                        n_st.start  = 6'(e_cs);
                        n_st.length = w_len[6:0];
                    end
                end
            end else if (i_ctrl.char_value == w_pair[7:0]) begin
                n_seek = 1'b1;
                if (e_prog == 3'd0) begin
                    n_cs = i_pos;
                end
            end
        end

        if (i_ctrl.last) begin
            n_prog = 3'd0;
            n_seek = 1'b0;
            n_cs   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog <= 3'd0;
            r_seek <= 1'b0;
            r_cs   <= '0;
            r_st   <= '0;
        end else begin
            r_prog <= n_prog;
            r_seek <= n_seek;
            r_cs   <= n_cs;
            r_st   <= n_st;
        end
    end

    assign o_match = n_st.found ? n_st : '0;

endmodule

[design/dpsm_report_queue.sv]
// One pending report snapshot and the serializer that sends it beat by beat.
module dpsm_report_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [2:0]                i_nr,
    input  dpsm_pkg::t_match          i_match [dpsm_pkg::RULES_HW],
    output logic                      o_full,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [dpsm_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                      o_m_tlast
);

    logic                                r_snap_vld;
    logic [2:0]                          r_snap_nr;
    dpsm_pkg::t_match                    r_snap_match [dpsm_pkg::RULES_HW];
    logic                                r_ser_vld;
    logic [dpsm_pkg::RULE_IDX_W-1:0]     r_ser_idx;
    logic [2:0]                          r_ser_nr;
    dpsm_pkg::t_match                    r_ser_match [dpsm_pkg::RULES_HW];
    logic                                w_take;
    logic                                w_last;
    logic                                w_free;
    logic                                w_load;
    dpsm_pkg::t_match                    w_cur;

    assign w_last = (3'(r_ser_idx) + 3'd1 == r_ser_nr);
    assign w_take = r_ser_vld && i_m_tready;
    assign w_free = !r_ser_vld || (w_take && w_last);
    assign w_load = w_free && r_snap_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_vld <= 1'b0;
            r_ser_vld  <= 1'b0;
            r_ser_idx  <= '0;
        end else begin
            if (w_free) begin
                r_ser_vld <= r_snap_vld;
                r_ser_idx <= '0;
            end else if (w_take) begin
                r_ser_idx <= r_ser_idx + 2'd1;
            end
            if (i_push) begin
                r_snap_vld <= 1'b1;
            end else if (w_free) begin
                r_snap_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_snap_nr    <= i_nr;
            r_snap_match <= i_match;
        end
        if (w_load) begin
            r_ser_nr    <= r_snap_nr;
            r_ser_match <= r_snap_match;
        end
    end

    assign w_cur      = r_ser_match[r_ser_idx];
    assign o_full     = r_snap_vld && !w_free;
    assign o_m_tvalid = r_ser_vld;
    assign o_m_tlast  = w_last;
    assign o_m_tdata  = {5'd0, w_cur.length, w_cur.start, w_cur.slot, w_cur.found, r_ser_idx};

endmodule

[tb/dpsm_tb_pkg.sv]
// Register map constants shared by the matcher testbench and its checker.
package dpsm_tb_pkg;

    localparam int ADDR_STRIDE = 8;

    typedef enum logic [2:0] {
        REG_RULE_COUNT  = 3'd0,
        REG_PATTERN_0   = 3'd1,
        REG_PATTERN_1   = 3'd2,
        REG_PATTERN_2   = 3'd3,
        REG_PATTERN_3   = 3'd4,
        REG_PAIR_COUNTS = 3'd5
    } t_reg_index;

endpackage

[tb/dpsm_report_checker.sv]
// Checker that predicts the matcher's rule reports and compares every report beat.
module dpsm_report_checker #(
    parameter int SLOT_COUNT     = 8,
    parameter int SLOT_BYTES     = 64,
    parameter int RULE_COUNT_MAX = 4,
    parameter int PAIRS_MAX      = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic [3:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]       rule;
        dpsm_pkg::t_match m;
        logic             last;
    } t_rule_report;

    logic [2:0]                     cfg_rules_on;
    logic [dpsm_pkg::PATTERN_W-1:0] cfg_pattern[dpsm_pkg::RULES_HW];
    logic [11:0]                    cfg_pair_counts;

    logic [6:0]       byte_pos;
    logic             string_done;
    logic [2:0]       pair_idx[dpsm_pkg::RULES_HW];
    logic             want_close[dpsm_pkg::RULES_HW];
    logic [5:0]       open_pos[dpsm_pkg::RULES_HW];
    dpsm_pkg::t_match stored[dpsm_pkg::RULES_HW];
    t_rule_report     expected_reports[$];
    int               mismatches = 0;

    function automatic void begin_string();
        byte_pos = '0;
        string_done = 1'b0;
        for (int r = 0; r < dpsm_pkg::RULES_HW; r++) begin
            pair_idx[r] = '0;
            want_close[r] = 1'b0;
            open_pos[r] = '0;
        end
    endfunction

    function automatic void clear_matches();
        for (int r = 0; r < dpsm_pkg::RULES_HW; r++) begin
            stored[r] = '0;
        end
    endfunction

    function automatic void advance_rule(input int r, input logic [7:0] ch,
                                         input logic [2:0] slot);
        int          cnt;
        logic [15:0] pair;
        cnt = int'(cfg_pair_counts[3*r +: 3]);
        if (cnt == 0 || cnt > PAIRS_MAX || pair_idx[r] >= cnt) return;
        pair = cfg_pattern[r][16*pair_idx[r][1:0] +: 16];
        if (want_close[r]) begin
            if (ch == pair[15:8]) begin
                want_close[r] = 1'b0;
                pair_idx[r] = pair_idx[r] + 3'd1;
                if (pair_idx[r] == cnt && !stored[r].found && int'(slot) < SLOT_COUNT) begin
                    stored[r].found = 1'b1;
                    stored[r].slot = slot;
                    stored[r].start = open_pos[r];
                    stored[r].length = 7'(byte_pos - open_pos[r] + 1);
                end
            end
        end else if (ch == pair[7:0]) begin
            want_close[r] = 1'b1;
            if (pair_idx[r] == 0) open_pos[r] = byte_pos[5:0];
        end
    endfunction

    task automatic absorb_byte(input logic sc, input logic [2:0] slot, input logic [7:0] ch,
                               input logic last);
        int           active;
        logic         report;
        t_rule_report rep;
        active = (cfg_rules_on > RULE_COUNT_MAX) ? RULE_COUNT_MAX : int'(cfg_rules_on);
        report = 1'b0;
        if (sc) begin
            clear_matches();
            begin_string();
        end
        if (!string_done) begin
            if (ch == 8'h00) begin
                string_done = 1'b1;
                report = 1'b1;
            end else if (byte_pos < SLOT_BYTES) begin
                for (int r = 0; r < active; r++) advance_rule(r, ch, slot);
                byte_pos = byte_pos + 7'd1;
            end
        end
        if (last) begin
            if (!string_done) report = 1'b1;
            begin_string();
        end
        if (report) begin
            for (int r = 0; r < active; r++) begin
                rep.rule = 2'(r);
                rep.m = stored[r].found ? stored[r] : '0;
                rep.last = (r == active - 1);
                expected_reports.push_back(rep);
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [6:0] want,
                                        input logic [6:0] got);
        if (got !== want) begin
            if (mismatches < 100) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
            mismatches++;
        end
    endfunction

    task automatic check_report(input logic [23:0] data, input logic last);
        t_rule_report want;
        if (expected_reports.size() == 0) begin
            if (mismatches < 100) begin
                $display("%0t: report beat with nothing expected, actual data %h last %0b",
                         $time, data, last);
            end
            mismatches++;
            return;
        end
        want = expected_reports.pop_front();
        check_field("rule_id", 7'(want.rule), 7'(data[1:0]));
        check_field("found", 7'(want.m.found), 7'(data[2]));
        check_field("match_slot", 7'(want.m.slot), 7'(data[5:3]));
        check_field("match_start", 7'(want.m.start), 7'(data[11:6]));
        check_field("match_length", want.m.length, data[18:12]);
        check_field("last_report", 7'(want.last), 7'(last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_rules_on = '0;
            cfg_pair_counts = '0;
            for (int r = 0; r < dpsm_pkg::RULES_HW; r++) cfg_pattern[r] = '0;
            begin_string();
            clear_matches();
            expected_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (dpsm_tb_pkg::t_reg_index'(paddr / dpsm_tb_pkg::ADDR_STRIDE))
                    dpsm_tb_pkg::REG_RULE_COUNT:  cfg_rules_on = pwdata[2:0];
                    dpsm_tb_pkg::REG_PATTERN_0:   cfg_pattern[0] = pwdata;
                    dpsm_tb_pkg::REG_PATTERN_1:   cfg_pattern[1] = pwdata;
                    dpsm_tb_pkg::REG_PATTERN_2:   cfg_pattern[2] = pwdata;
                    dpsm_tb_pkg::REG_PATTERN_3:   cfg_pattern[3] = pwdata;
                    dpsm_tb_pkg::REG_PAIR_COUNTS: cfg_pair_counts = pwdata[11:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_byte(s_axis_tuser[0], s_axis_tuser[3:1], s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) check_report(m_axis_tdata, m_axis_tlast);
        end
        o_pending <= expected_reports.size();
        o_fail_count <= mismatches;
    end

endmodule

[tb/tb_delimiter_pair_sequence_matcher.sv]
// Top of the matcher testbench: clock, reset, register writes, byte stimulus and verdict.
module tb_delimiter_pair_sequence_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int STIMULUS_ITEMS = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // char_value
    logic [3:0]  s_axis_tuser = '0;     // scan_start, slot_index[2:0]
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // rule_id[1:0], found, match_slot[2:0],
                                        // match_start[5:0], match_length[6:0], zero pad
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          items_sent = 0;
    int          rx_wait = 0;
    logic        tx_fast = 1'b0;
    logic        rx_fast = 1'b0;
    logic [7:0]  alphabet[6];

    always #5ns i_clk = ~i_clk;

    delimiter_pair_sequence_matcher u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    dpsm_report_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // The receiver stalls for a randomly drawn time after each report beat, except in fast receive mode.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wait = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) rx_wait = rx_fast ? 0 : $urandom_range(0, 9);
            if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(input dpsm_tb_pkg::t_reg_index idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 6'(int'(idx) * dpsm_tb_pkg::ADDR_STRIDE);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_byte(input logic sc, input logic [2:0] slot, input logic [7:0] ch,
                             input logic last);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ch;
        s_axis_tuser <= {slot, sc};
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_string(input logic sc, input logic [2:0] slot, input logic [7:0] text[$]);
        for (int i = 0; i < text.size(); i++) begin
            push_byte(sc && i == 0, slot, text[i], i == text.size() - 1);
        end
    endtask

    task automatic wait_idle(input int settle);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0]  text[$];
        logic [63:0] pattern;
        logic [11:0] pair_counts;
        logic [2:0]  rules_on;
        int          phase;
        int          strings;
        int          len;
        int          pick;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Rule 0 needs "()" then "[]", rule 1 needs FF then 01, rules 2 and 3 are disabled.
        write_reg(dpsm_tb_pkg::REG_RULE_COUNT, 64'd4);
        write_reg(dpsm_tb_pkg::REG_PATTERN_0, 64'h0000_0000_5D5B_2928);
        write_reg(dpsm_tb_pkg::REG_PATTERN_1, 64'h0000_0000_0000_01FF);
        write_reg(dpsm_tb_pkg::REG_PATTERN_2, 64'h0000_0000_5D5B_2928);
        write_reg(dpsm_tb_pkg::REG_PATTERN_3, '1);
        write_reg(dpsm_tb_pkg::REG_PAIR_COUNTS, 64'(12'b101_000_001_010));

        text = '{8'h78, 8'h28, 8'h61, 8'h29, 8'h5B, 8'h62, 8'h5D};
        send_string(1'b1, 3'd7, text);
        text = '{8'hFF, 8'h01, 8'h00, 8'h7E};
        send_string(1'b0, 3'd2, text);
        text = '{8'h28, 8'h29, 8'h5B};
        send_string(1'b0, 3'd5, text);
        text = '{8'h00};
        send_string(1'b1, 3'd0, text);
        wait_idle(4);

        write_reg(dpsm_tb_pkg::REG_RULE_COUNT, 64'd0);
        text = '{8'h28, 8'h29};
        send_string(1'b0, 3'd3, text);
        wait_idle(4);

        write_reg(dpsm_tb_pkg::REG_RULE_COUNT, 64'd7);
        text = '{8'h28, 8'h29, 8'h5B, 8'h5D};
        send_string(1'b1, 3'd4, text);
        wait_idle(4);

        phase = 0;
        while (items_sent < STIMULUS_ITEMS) begin
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(1, 255));

            if (phase == 1) begin
                write_reg(dpsm_tb_pkg::REG_RULE_COUNT, 64'd7);
                for (int r = 0; r < dpsm_pkg::RULES_HW; r++) begin
                    write_reg(dpsm_tb_pkg::t_reg_index'(dpsm_tb_pkg::REG_PATTERN_0 + r), '1);
                end
                write_reg(dpsm_tb_pkg::REG_PAIR_COUNTS, 64'h0FFF);
            end else if (phase == 2) begin
                write_reg(dpsm_tb_pkg::REG_RULE_COUNT, 64'd4);
                for (int r = 0; r < dpsm_pkg::RULES_HW; r++) begin
                    write_reg(dpsm_tb_pkg::t_reg_index'(dpsm_tb_pkg::REG_PATTERN_0 + r), '0);
                end
                write_reg(dpsm_tb_pkg::REG_PAIR_COUNTS, 64'd0);
            end else begin
                rules_on = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7))
                                                       : 3'($urandom_range(1, 4));
                write_reg(dpsm_tb_pkg::REG_RULE_COUNT, 64'(rules_on));
                for (int r = 0; r < dpsm_pkg::RULES_HW; r++) begin
                    for (int k = 0; k < 8; k++) pattern[8*k +: 8] = alphabet[$urandom_range(0, 5)];
                    write_reg(dpsm_tb_pkg::t_reg_index'(dpsm_tb_pkg::REG_PATTERN_0 + r), pattern);
                end
                for (int r = 0; r < dpsm_pkg::RULES_HW; r++) begin
                    pair_counts[3*r +: 3] = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                                       : 3'($urandom_range(1, 4));
                end
                write_reg(dpsm_tb_pkg::REG_PAIR_COUNTS, 64'(pair_counts));
            end

            repeat ($urandom_range(1, 3)) begin
                strings = $urandom_range(1, 5);
                for (int s = 0; s < strings && items_sent < STIMULUS_ITEMS; s++) begin
                    pick = $urandom_range(0, 99);
                    len = (pick < 5) ? $urandom_range(62, 70) :
                          (pick < 10) ? 1 : $urandom_range(2, 16);
                    text.delete();
                    repeat (len) begin
                        pick = $urandom_range(0, 99);
                        text.push_back((pick < 4) ? 8'h00 :
                                       (pick < 80) ? alphabet[$urandom_range(0, 5)] :
                                       8'($urandom));
                    end
                    send_string(s == 0, 3'($urandom), text);
                end
            end
            wait_idle(4);
            phase++;
        end

        wait_idle(8);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
